FILE: src/three_voice_wavetable_oscillator_core_defines.svh
// Assertion macros used by the oscillator top level.
`ifndef THREE_VOICE_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH
`define THREE_VOICE_WAVETABLE_OSCILLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TWVO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twvo check failed");

// Next-cycle implication, disabled during reset.
`define TWVO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twvo check failed");

`endif

FILE: src/twvo_pkg.sv
// Shared constants, types and the period table of the wavetable oscillator.
`default_nettype none
package twvo_pkg;

  localparam int NUM_VOICES  = 3;
  localparam int WAVE_STEPS  = 64;
  localparam int NUM_WAVES   = 4;
  localparam int SAMPLE_BITS = 16;

  localparam int NUM_OCTAVES = 5;
  localparam int NUM_NOTES   = 12;
  localparam int OUT_VOICES  = 3;

  // field widths of the channels
  localparam int ACTION_W = 2;
  localparam int VOICE_W  = 2;
  localparam int NOTE_W   = 4;
  localparam int OCTAVE_W = 3;
  localparam int WNUM_W   = 2;
  localparam int WIDX_W   = 6;
  localparam int WVAL_W   = 16;
  localparam int OUT_W    = 16;
  localparam int WSEL_W   = 2;

  localparam int PERIOD_W   = 16;
  localparam int PHASE_W    = $clog2(WAVE_STEPS);
  localparam int WAVE_SEL_W = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
  localparam int ADDR_W     = WAVE_SEL_W + PHASE_W;
  localparam int WAVE_DEPTH = NUM_WAVES * WAVE_STEPS;

  localparam logic [WSEL_W-1:0] WAVE_SEL_RESET = WSEL_W'(2);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SET  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd3;

  // timer reload per octave and semitone
  localparam logic [PERIOD_W-1:0] PERIOD_ROM [NUM_OCTAVES][NUM_NOTES] = '{
    '{16'd8600, 16'd8117, 16'd7662, 16'd7232, 16'd6826, 16'd6443,
      16'd6081, 16'd5740, 16'd5418, 16'd5114, 16'd4827, 16'd4556},
    '{16'd4300, 16'd4059, 16'd3831, 16'd3616, 16'd3413, 16'd3221,
      16'd3041, 16'd2870, 16'd2709, 16'd2557, 16'd2413, 16'd2278},
    '{16'd2150, 16'd2029, 16'd1915, 16'd1808, 16'd1706, 16'd1611,
      16'd1520, 16'd1435, 16'd1354, 16'd1278, 16'd1207, 16'd1139},
    '{16'd1075, 16'd1015, 16'd958,  16'd903,  16'd853,  16'd805,
      16'd760,  16'd717,  16'd677,  16'd639,  16'd603,  16'd569},
    '{16'd538,  16'd507,  16'd479,  16'd452,  16'd427,  16'd403,
      16'd380,  16'd359,  16'd339,  16'd320,  16'd302,  16'd284}
  };

  // one input beat as held in the input register
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VOICE_W-1:0]  voice;
    logic [NOTE_W-1:0]   note;
    logic [OCTAVE_W-1:0] octave;
    logic [WNUM_W-1:0]   wave_number;
    logic [WIDX_W-1:0]   wave_index;
    logic [WVAL_W-1:0]   wave_sample;
  } item_t;

  // per-voice command from the decode logic
  typedef struct packed {
    logic                tick;
    logic                set;
    logic                off;
    logic [PERIOD_W-1:0] reload;
  } vcmd_t;

endpackage
`default_nettype wire

FILE: src/twvo_if.sv
// Valid/ready channel interfaces for the oscillator input and result beats.
`default_nettype none
interface twvo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  voice;
  logic [3:0]  note;
  logic [2:0]  octave;
  logic [1:0]  wave_number;
  logic [5:0]  wave_index;
  logic [15:0] wave_sample;

  modport source (output valid, action, voice, note, octave, wave_number,
                  wave_index, wave_sample, input ready);
  modport sink (input valid, action, voice, note, octave, wave_number,
                wave_index, wave_sample, output ready);
endinterface

interface twvo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_voice0;
  logic [15:0] sample_voice1;
  logic [15:0] sample_voice2;
  logic        bad_note;

  modport source (output valid, sample_voice0, sample_voice1, sample_voice2,
                  bad_note, input ready);
  modport sink (input valid, sample_voice0, sample_voice1, sample_voice2,
                bad_note, output ready);
endinterface
`default_nettype wire

FILE: src/twvo_wave_ram.sv
// Waveform sample RAM copy: one write port, one registered read port.
`default_nettype none
module twvo_wave_ram (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [twvo_pkg::ADDR_W-1:0]     wr_addr,
  input  wire logic [twvo_pkg::SAMPLE_BITS-1:0] wr_data,
  input  wire logic                            rd_en,
  input  wire logic [twvo_pkg::ADDR_W-1:0]     rd_addr,
  output logic      [twvo_pkg::SAMPLE_BITS-1:0] rd_data
);
  import twvo_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [WAVE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: src/twvo_voice.sv
// One voice: period counter, reload, enable and wavetable phase.
`default_nettype none
module twvo_voice (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire twvo_pkg::vcmd_t              cmd,
  input  wire logic [twvo_pkg::WSEL_W-1:0]  wave_sel,
  output logic                              rd_en,
  output logic      [twvo_pkg::ADDR_W-1:0]  rd_addr
);
  import twvo_pkg::*;

  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [PERIOD_W-1:0] reload_r, reload_nxt;
  logic                en_r, en_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                wrap;
  logic [PHASE_W-1:0]  phase_inc;

  assign wrap      = (cnt_r >= reload_r);
  assign phase_inc = (phase_r == PHASE_W'(WAVE_STEPS - 1)) ? '0 : phase_r + 1'b1;

  // sample fetch on wrap; selected wave taken modulo the wave count
  assign rd_en   = step && cmd.tick && en_r && wrap;
  assign rd_addr = {wave_sel[WAVE_SEL_W-1:0], phase_r};

  // next state
  always_comb begin
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    en_nxt     = en_r;
    phase_nxt  = phase_r;
    if (step) begin
      if (cmd.tick && en_r) begin
        if (wrap) begin
          cnt_nxt   = '0;
          phase_nxt = phase_inc;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      if (cmd.set) begin
        reload_nxt = cmd.reload;
        en_nxt     = 1'b1;
      end
      if (cmd.off) begin
        reload_nxt = '0;
        en_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      reload_r <= '0;
      en_r     <= 1'b0;
      phase_r  <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      reload_r <= reload_nxt;
      en_r     <= en_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/three_voice_wavetable_oscillator_core.sv
// Top level of the three-voice wavetable oscillator.
//
//   channel   dir   beat contents
//   in_bus    in    action, voice, note, octave, wave_number, wave_index, wave_sample
//   out_bus   out   sample_voice0..2, bad_note
//   cfg_wr_*  in    wave_select (2 bits), no handshake
//
// One beat per cycle sustained while out_bus takes results; a result passes through the
// input register, the voice update with RAM fetch and the latched-sample output register.
// Each voice has its own RAM copy, so all voices can fetch on the same tick.
// Reset clears the voices and latched samples; the waveform RAM holds no reset value.
// A stall on out_bus backs up one stage at a time; in_bus stays ready while any
// stage ahead has room.
`default_nettype none
`include "three_voice_wavetable_oscillator_core_defines.svh"
module three_voice_wavetable_oscillator_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  twvo_in_if.sink                          in_bus,
  twvo_out_if.source                       out_bus,
  input  wire logic                        cfg_wr_en,
  input  wire logic [twvo_pkg::WSEL_W-1:0] cfg_wr_data
);
  import twvo_pkg::*;

  logic [WSEL_W-1:0] wave_sel_r;

  logic  a_valid_r, b_valid_r, c_valid_r;
  item_t a_item_r;
  logic  ready_b, ready_c, move_ab, move_bc, accept;

  logic               set_ok, bad_nxt, load_ok;
  vcmd_t              vcmd    [NUM_VOICES];
  logic               rd_en   [NUM_VOICES];
  logic [ADDR_W-1:0]  rd_addr [NUM_VOICES];
  logic [SAMPLE_BITS-1:0] ram_q [NUM_VOICES];
  logic [ADDR_W-1:0]  wr_addr;
  logic [PERIOD_W-1:0] rom_period;

  logic                   b_latch_r [NUM_VOICES];
  logic                   b_off_r   [NUM_VOICES];
  logic                   b_bad_r;
  logic [SAMPLE_BITS-1:0] lat_r   [NUM_VOICES];
  logic [SAMPLE_BITS-1:0] lat_nxt [NUM_VOICES];
  logic                   c_bad_r;
  logic [OUT_W-1:0]       out_sample [OUT_VOICES];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r <= WAVE_SEL_RESET;
    end else if (cfg_wr_en) begin
      wave_sel_r <= cfg_wr_data;
    end
  end

  // stage handshakes
  assign ready_c      = !c_valid_r || out_bus.ready;
  assign move_bc      = b_valid_r && ready_c;
  assign ready_b      = !b_valid_r || ready_c;
  assign move_ab      = a_valid_r && ready_b;
  assign in_bus.ready = !a_valid_r || ready_b;
  assign accept       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (accept)       a_valid_r <= 1'b1;
      else if (move_ab) a_valid_r <= 1'b0;
      if (move_ab)      b_valid_r <= 1'b1;
      else if (move_bc) b_valid_r <= 1'b0;
      if (move_bc)      c_valid_r <= 1'b1;
      else if (out_bus.ready) c_valid_r <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= '{action: in_bus.action, voice: in_bus.voice, note: in_bus.note,
                    octave: in_bus.octave, wave_number: in_bus.wave_number,
                    wave_index: in_bus.wave_index, wave_sample: in_bus.wave_sample};
    end
  end

  // decode: note range check, period lookup, RAM write
  assign set_ok  = (a_item_r.note < NOTE_W'(NUM_NOTES)) &&
                   (a_item_r.octave < OCTAVE_W'(NUM_OCTAVES));
  assign bad_nxt = (a_item_r.action == ACT_SET) && !set_ok;
  assign rom_period = set_ok ? PERIOD_ROM[a_item_r.octave][a_item_r.note] : '0;
  assign load_ok = (a_item_r.action == ACT_LOAD) &&
                   (32'(a_item_r.wave_number) < 32'(NUM_WAVES)) &&
                   (32'(a_item_r.wave_index) < 32'(WAVE_STEPS));
  assign wr_addr = {a_item_r.wave_number[WAVE_SEL_W-1:0],
                    a_item_r.wave_index[PHASE_W-1:0]};

  // voices and their RAM copies
  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
    assign vcmd[v].tick   = (a_item_r.action == ACT_TICK);
    assign vcmd[v].set    = (a_item_r.action == ACT_SET) && set_ok &&
                            (a_item_r.voice == VOICE_W'(v));
    assign vcmd[v].off    = (a_item_r.action == ACT_OFF) &&
                            (a_item_r.voice == VOICE_W'(v));
    assign vcmd[v].reload = rom_period;

    twvo_voice u_voice (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (move_ab),
      .cmd      (vcmd[v]),
      .wave_sel (wave_sel_r),
      .rd_en    (rd_en[v]),
      .rd_addr  (rd_addr[v])
    );

    twvo_wave_ram u_ram (
      .clk     (clk),
      .wr_en   (move_ab && load_ok),
      .wr_addr (wr_addr),
      .wr_data (a_item_r.wave_sample[SAMPLE_BITS-1:0]),
      .rd_en   (rd_en[v]),
      .rd_addr (rd_addr[v]),
      .rd_data (ram_q[v])
    );

    // middle stage flags
    always_ff @(posedge clk) begin
      if (move_ab) begin
        b_latch_r[v] <= rd_en[v];
        b_off_r[v]   <= vcmd[v].off;
      end
    end

    // latched sample, updated as the beat enters the output register
    always_comb begin
      lat_nxt[v] = lat_r[v];
      if (move_bc) begin
        if (b_latch_r[v])    lat_nxt[v] = ram_q[v];
        else if (b_off_r[v]) lat_nxt[v] = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lat_r[v] <= '0;
      end else begin
        lat_r[v] <= lat_nxt[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_ab) begin
      b_bad_r <= bad_nxt;
    end
    if (move_bc) begin
      c_bad_r <= b_bad_r;
    end
  end

  // result fields; a voice that is not built reads as zero
  for (genvar k = 0; k < OUT_VOICES; k++) begin : g_out
    if (k < NUM_VOICES) begin : g_on
      assign out_sample[k] = OUT_W'(lat_r[k]);
    end else begin : g_off
      assign out_sample[k] = '0;
    end
  end

  assign out_bus.valid         = c_valid_r;
  assign out_bus.sample_voice0 = out_sample[0];
  assign out_bus.sample_voice1 = out_sample[1];
  assign out_bus.sample_voice2 = out_sample[2];
  assign out_bus.bad_note      = c_bad_r;

  // checks
  `TWVO_ASSERT_NEXT(a_bad_only_on_set, move_ab && (a_item_r.action != ACT_SET), !b_bad_r)
  `TWVO_ASSERT_NEXT(a_fetch_flagged, move_ab && rd_en[0], b_latch_r[0])
  `TWVO_ASSERT_NEXT(a_off_clears, move_bc && b_off_r[0], lat_r[0] == '0)
  `TWVO_ASSERT_NOW(a_fetch_tick_only, rd_en[0], move_ab && (a_item_r.action == ACT_TICK))

endmodule
`default_nettype wire

FILE: tb/sv/three_voice_wavetable_oscillator_core_test.sv
// Self-checking testbench for the three-voice wavetable oscillator core.
`timescale 1ns / 100ps
module three_voice_wavetable_oscillator_core_test;
  import twvo_pkg::*;

  // one expected result beat
  typedef struct packed {
    logic [15:0] sample_voice0;
    logic [15:0] sample_voice1;
    logic [15:0] sample_voice2;
    logic        bad_note;
  } osc_result_t;

  // timer reload per octave and semitone
  localparam logic [15:0] NOTE_PERIOD [5][12] = '{
    '{16'd8600, 16'd8117, 16'd7662, 16'd7232, 16'd6826, 16'd6443,
      16'd6081, 16'd5740, 16'd5418, 16'd5114, 16'd4827, 16'd4556},
    '{16'd4300, 16'd4059, 16'd3831, 16'd3616, 16'd3413, 16'd3221,
      16'd3041, 16'd2870, 16'd2709, 16'd2557, 16'd2413, 16'd2278},
    '{16'd2150, 16'd2029, 16'd1915, 16'd1808, 16'd1706, 16'd1611,
      16'd1520, 16'd1435, 16'd1354, 16'd1278, 16'd1207, 16'd1139},
    '{16'd1075, 16'd1015, 16'd958,  16'd903,  16'd853,  16'd805,
      16'd760,  16'd717,  16'd677,  16'd639,  16'd603,  16'd569},
    '{16'd538,  16'd507,  16'd479,  16'd452,  16'd427,  16'd403,
      16'd380,  16'd359,  16'd339,  16'd320,  16'd302,  16'd284}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [WSEL_W-1:0] cfg_wr_data = '0;

  twvo_in_if  in_ch ();
  twvo_out_if out_ch ();

  three_voice_wavetable_oscillator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_ch),
    .out_bus     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [15:0]       osc_count  [3];
  logic [15:0]       osc_reload [3];
  logic              osc_on     [3];
  logic [5:0]        osc_phase  [3];
  logic [15:0]       osc_sample [3];
  logic [15:0]       wave_mem   [256];
  logic [WSEL_W-1:0] wave_sel_q;

  osc_result_t pending_results [$];
  int          fail_count  = 0;
  int          tx_idle_pct = 19;
  int          rx_idle_pct = 74;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // apply one accepted beat to the predicted state, return the result it causes
  function automatic osc_result_t advance_oscillator(input item_t b);
    osc_result_t r;
    int v;
    r.bad_note = 1'b0;
    case (b.action)
      ACT_TICK: begin
        for (v = 0; v < 3; v++) begin
          if (osc_on[v]) begin
            if (osc_count[v] >= osc_reload[v]) begin
              osc_count[v]  = '0;
              osc_sample[v] = wave_mem[{wave_sel_q, osc_phase[v]}];
              osc_phase[v]  = osc_phase[v] + 6'd1;
            end else begin
              osc_count[v] = osc_count[v] + 16'd1;
            end
          end
        end
      end
      ACT_SET: begin
        if (b.note >= 4'd12 || b.octave >= 3'd5) begin
          r.bad_note = 1'b1;
        end else if (b.voice < 2'd3) begin
          osc_reload[b.voice] = NOTE_PERIOD[b.octave][b.note];
          osc_on[b.voice]     = 1'b1;
        end
      end
      ACT_OFF: begin
        if (b.voice < 2'd3) begin
          osc_sample[b.voice] = '0;
          osc_reload[b.voice] = '0;
          osc_on[b.voice]     = 1'b0;
        end
      end
      default: begin
        wave_mem[{b.wave_number, b.wave_index}] = b.wave_sample;
      end
    endcase
    r.sample_voice0 = osc_sample[0];
    r.sample_voice1 = osc_sample[1];
    r.sample_voice2 = osc_sample[2];
    return r;
  endfunction

  function automatic item_t mk_beat(input logic [1:0] action, input logic [1:0] voice,
                                    input logic [3:0] note, input logic [2:0] octave,
                                    input logic [1:0] wnum, input logic [5:0] widx,
                                    input logic [15:0] wsample);
    item_t b;
    b.action      = action;
    b.voice       = voice;
    b.note        = note;
    b.octave      = octave;
    b.wave_number = wnum;
    b.wave_index  = widx;
    b.wave_sample = wsample;
    return b;
  endfunction

  // drive one beat, with random idle cycles ahead of it
  task automatic send_beat(input item_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= b.action;
    in_ch.voice       <= b.voice;
    in_ch.note        <= b.note;
    in_ch.octave      <= b.octave;
    in_ch.wave_number <= b.wave_number;
    in_ch.wave_index  <= b.wave_index;
    in_ch.wave_sample <= b.wave_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(advance_oscillator(b));
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic set_wave_select(input logic [WSEL_W-1:0] sel);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    wave_sel_q = sel;
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    osc_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.sample_voice0 !== exp_r.sample_voice0) begin
          $error("sample_voice0 expected %h actual %h", exp_r.sample_voice0,
                 out_ch.sample_voice0);
          fail_count++;
        end
        if (out_ch.sample_voice1 !== exp_r.sample_voice1) begin
          $error("sample_voice1 expected %h actual %h", exp_r.sample_voice1,
                 out_ch.sample_voice1);
          fail_count++;
        end
        if (out_ch.sample_voice2 !== exp_r.sample_voice2) begin
          $error("sample_voice2 expected %h actual %h", exp_r.sample_voice2,
                 out_ch.sample_voice2);
          fail_count++;
        end
        if (out_ch.bad_note !== exp_r.bad_note) begin
          $error("bad_note expected %b actual %b", exp_r.bad_note, out_ch.bad_note);
          fail_count++;
        end
      end
    end
  end

  // ticks and voice-off with every voice still disabled
  task automatic test_idle_voices();
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_OFF, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd3, 4'd15, 3'd7, 2'd3, 6'd63, 16'hFFFF));
  endtask

  // fill every waveform entry before any voice plays
  task automatic test_wave_fill();
    int w;
    int i;
    for (w = 0; w < 4; w++) begin
      for (i = 0; i < 64; i++) begin
        send_beat(mk_beat(ACT_LOAD, 2'($urandom_range(3)), 4'($urandom_range(15)),
                          3'($urandom_range(7)), 2'(w), 6'(i),
                          16'($urandom_range(16'hFFFF))));
      end
    end
  endtask

  // note or octave out of range, on valid and invalid voices
  task automatic test_bad_notes();
    send_beat(mk_beat(ACT_SET, 2'd0, 4'd12, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd1, 4'd0, 3'd5, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd3, 4'd15, 3'd7, 2'd3, 6'd63, 16'hFFFF));
    send_beat(mk_beat(ACT_SET, 2'd2, 4'd11, 3'd7, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
  endtask

  // set note and voice off aimed at the missing fourth voice
  task automatic test_voice_bounds();
    send_beat(mk_beat(ACT_SET, 2'd3, 4'd11, 3'd4, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_OFF, 2'd3, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
  endtask

  // slowest and fastest notes, load extremes, voice off then on again
  task automatic test_field_extremes();
    send_beat(mk_beat(ACT_LOAD, 2'd3, 4'd0, 3'd0, 2'd3, 6'd63, 16'hFFFF));
    send_beat(mk_beat(ACT_LOAD, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd2, 4'd11, 3'd4, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd1, 4'd5, 3'd2, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_OFF, 2'd2, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd2, 4'd9, 3'd4, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_TICK, 2'd0, 4'd0, 3'd0, 2'd0, 6'd0, 16'h0000));
  endtask

  // all three voices on short periods, long enough for each voice to latch
  task automatic test_fast_voices();
    int n;
    set_wave_select(2'd3);
    send_beat(mk_beat(ACT_SET, 2'd0, 4'd11, 3'd4, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd1, 4'd10, 3'd4, 2'd0, 6'd0, 16'h0000));
    send_beat(mk_beat(ACT_SET, 2'd2, 4'd9, 3'd4, 2'd0, 6'd0, 16'h0000));
    for (n = 0; n < 330; n++) begin
      send_beat(mk_beat(ACT_TICK, 2'($urandom_range(3)), 4'($urandom_range(15)),
                        3'($urandom_range(7)), 2'($urandom_range(3)),
                        6'($urandom_range(63)), 16'($urandom_range(16'hFFFF))));
    end
  endtask

  // mostly ticks, with note changes, voice-offs and waveform rewrites mixed in
  task automatic test_random_traffic(input int count);
    item_t b;
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      b = mk_beat(ACT_TICK, 2'($urandom_range(3)), 4'($urandom_range(15)),
                  3'($urandom_range(7)), 2'($urandom_range(3)),
                  6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)));
      pick = $urandom_range(99);
      if (pick < 82) begin
        b.action = ACT_TICK;
      end else if (pick < 91) begin
        b.action = ACT_SET;
        // most notes in range, favoring the fastest octave so voices latch
        if ($urandom_range(4) != 0) begin
          b.note   = 4'($urandom_range(11));
          b.octave = ($urandom_range(1) != 0) ? 3'd4 : 3'($urandom_range(4));
        end
      end else if (pick < 95) begin
        b.action = ACT_OFF;
      end else begin
        b.action = ACT_LOAD;
      end
      send_beat(b);
    end
  endtask

  // test sequence
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_TICK;
    in_ch.voice       = '0;
    in_ch.note        = '0;
    in_ch.octave      = '0;
    in_ch.wave_number = '0;
    in_ch.wave_index  = '0;
    in_ch.wave_sample = '0;
    osc_count   = '{default: '0};
    osc_reload  = '{default: '0};
    osc_on      = '{default: 1'b0};
    osc_phase   = '{default: '0};
    osc_sample  = '{default: '0};
    wave_mem    = '{default: '0};
    wave_sel_q  = WAVE_SEL_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender lightly idle, receiver mostly stalled
    tx_idle_pct = 19;
    rx_idle_pct = 74;
    test_idle_voices();
    test_wave_fill();
    test_bad_notes();
    test_voice_bounds();
    test_field_extremes();
    set_wave_select(2'd0);
    test_random_traffic(60);

    // sender mostly idle, receiver lightly stalled
    tx_idle_pct = 74;
    rx_idle_pct = 19;
    set_wave_select(2'd1);
    test_random_traffic(60);

    // full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_fast_voices();
    set_wave_select(2'd2);
    test_random_traffic(60);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/twvo_pkg.sv
src/twvo_if.sv
src/twvo_wave_ram.sv
src/twvo_voice.sv
src/three_voice_wavetable_oscillator_core.sv
tb/sv/three_voice_wavetable_oscillator_core_test.sv
